// ----- sv/bfds_pkg.sv -----
// Shared types and constants for the byte FIFO with drop statistics.
package bfds_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int FILL_W          = 7;
    localparam int CNT_W           = 32;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 112;
    localparam int STATUS_W        = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_ARG = 2'd3
    } status_t;

    typedef enum logic {
        KIND_SUBMIT = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_DROP,
        OP_REJECT_EMPTY,
        OP_REJECT_ARG,
        OP_START_READ,
        OP_POP
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic req_zero;
        logic remain_one;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- sv/bfds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bfds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bfds_ctrl.sv -----
// Controller: accepts items and sequences the byte-by-byte read drain.
module bfds_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    output logic              s_tready,
    input  bfds_pkg::dp_sts_t sts,
    output bfds_pkg::op_t     op
);
    import bfds_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    if (kind_t'(s_tuser) == KIND_SUBMIT) begin
                        op = sts.full ? OP_DROP : OP_PUSH;
                    end else if (sts.req_zero) begin
                        op = OP_REJECT_ARG;
                    end else if (sts.empty) begin
                        op = OP_REJECT_EMPTY;
                    end else begin
                        op         = OP_START_READ;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                // advance one byte per free output slot
                if (sts.out_free) begin
                    op = OP_POP;
                    if (sts.remain_one) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/bfds_dp.sv -----
// Datapath: pointers, fill level, statistics counters, byte store and result register.
module bfds_dp #(
    parameter int QUEUE_DEPTH = bfds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bfds_pkg::S_TDATA_W-1:0] s_tdata,
    input  bfds_pkg::op_t                 op,
    output bfds_pkg::dp_sts_t             sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bfds_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [bfds_pkg::STATUS_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import bfds_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0]  head_reg, head_next, head_adv;
    logic [PTR_W-1:0]  tail_reg, tail_next, tail_adv;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0]  drop_reg, drop_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  drain_reg, drain_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic [BYTE_W-1:0] in_byte;
    logic [FILL_W-1:0] in_req;
    logic [BYTE_W-1:0] ram_rdata;
    logic [PTR_W-1:0]  ram_raddr;
    logic              ram_we;

    assign in_byte = s_tdata[BYTE_W-1:0];
    assign in_req  = s_tdata[BYTE_W+FILL_W-1:BYTE_W];

    assign head_adv = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign sts.full       = (fill_reg >= FILL_W'(QUEUE_DEPTH));
    assign sts.empty      = (fill_reg == '0);
    assign sts.req_zero   = (in_req == '0);
    assign sts.remain_one = (remain_reg == FILL_W'(1));
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign ram_we = (op == OP_PUSH);
    // prefetch the following slot when this byte leaves, else hold the current one
    assign ram_raddr = (op == OP_POP) ? head_adv : head_reg;

    bfds_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(in_byte),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        remain_next     = remain_reg;
        drop_next       = drop_reg;
        acc_next        = acc_reg;
        drain_next      = drain_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        unique case (op)
            OP_NONE: ;
            OP_PUSH: begin
                tail_next       = tail_adv;
                fill_next       = fill_reg + 1'b1;
                acc_next        = acc_reg + 1'b1;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_byte_next   = '0;
                out_last_next   = 1'b1;
            end
            OP_DROP: begin
                drop_next       = drop_reg + 1'b1;
                out_valid_next  = 1'b1;
                out_status_next = ST_FULL;
                out_byte_next   = '0;
                out_last_next   = 1'b1;
            end
            OP_REJECT_EMPTY: begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EMPTY;
                out_byte_next   = '0;
                out_last_next   = 1'b1;
            end
            OP_REJECT_ARG: begin
                out_valid_next  = 1'b1;
                out_status_next = ST_BAD_ARG;
                out_byte_next   = '0;
                out_last_next   = 1'b1;
            end
            OP_START_READ: begin
                remain_next = (in_req < fill_reg) ? in_req : fill_reg;
            end
            OP_POP: begin
                head_next       = head_adv;
                fill_next       = fill_reg - 1'b1;
                drain_next      = drain_reg + 1'b1;
                remain_next     = remain_reg - 1'b1;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_byte_next   = ram_rdata;
                out_last_next   = (remain_reg == FILL_W'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            remain_reg    <= '0;
            drop_reg      <= '0;
            acc_reg       <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
            drop_reg      <= drop_next;
            acc_reg       <= acc_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
    end

    // counters and fill level only change when a new result is loaded, so they match the held result
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {drain_reg, acc_reg, drop_reg, fill_reg, (fill_reg != '0), out_byte_reg};

endmodule

// ----- sv/byte_fifo_with_drop_stats.sv -----
// Top level: circular byte FIFO with drop, submit and read statistics.
// Submit and rejected reads: result in the cycle after the input transfer; one item per cycle
// while m_tready holds. Good read of N bytes: the controller enters its read state, then the
// bytes follow one per cycle while m_tready holds; s_tready stays low until the last byte.
// Reset clears pointers, fill level, counters and the result valid flag; the byte store
// is not cleared, as a slot is only read after it has been written.
module byte_fifo_with_drop_stats #(
    parameter int QUEUE_DEPTH = bfds_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfds_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], request_length[14:8]
    input  logic                           s_tuser,  // kind[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_byte[7:0], can_progress[8], buffered_count[15:9], dropped_count[47:16],
    // submitted_count[79:48], total_read_count[111:80]
    output logic [bfds_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [bfds_pkg::STATUS_W-1:0]  m_tuser,  // status[1:0]
    output logic                           m_tlast
);
    import bfds_pkg::*;

    op_t     op;
    dp_sts_t sts;

    bfds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tuser (s_tuser),
        .s_tready(s_tready),
        .sts     (sts),
        .op      (op)
    );

    bfds_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .op      (op),
        .sts     (sts),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ----- sv/bfds_check.sv -----
// Port-level checker for the byte FIFO, bound to the top level.
module bfds_check (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bfds_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bfds_pkg::STATUS_W-1:0]  m_tuser,
    input logic                           m_tlast
);
    import bfds_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // a submit transfer always yields a result on the next cycle
    a_submit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_SUBMIT) |=> m_tvalid)
        else $error("submit transfer produced no result");

    // any non-success result closes its item
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> m_tlast)
        else $error("error result not marked last");

    // can_progress tracks the fill level
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == (m_tdata[15:9] != 7'd0)))
        else $error("can_progress disagrees with buffered count");

    // while a byte result that is not last is taken, no input is accepted
    a_no_accept_midread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |-> !s_tready)
        else $error("input accepted in the middle of a read");

endmodule

bind byte_fifo_with_drop_stats bfds_check u_bfds_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
